// ----- rtl/core/sudi_pkg.sv -----
// ---------------------------------------------------------------------------
// sudi_pkg
// shared constants and types for the set union / difference / intersection
// engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sudi_pkg;

   // entries per set store
   localparam int DEPTH  = 16;
   localparam int ELEM_W = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [1:0]               code_type;

   // request modes
   localparam code_type MODE_FIRST  = 2'd0;
   localparam code_type MODE_SECOND = 2'd1;
   localparam code_type MODE_RUN    = 2'd2;

   // operations
   localparam code_type OP_UNION     = 2'd0;
   localparam code_type OP_DIFF      = 2'd1;
   localparam code_type OP_INTERSECT = 2'd2;

   localparam cnt_type DEPTH_CNT = cnt_type'(DEPTH);

endpackage : sudi_pkg

`default_nettype wire

// ----- rtl/core/sudi_store.sv -----
// ---------------------------------------------------------------------------
// sudi_store
// one set store: single write port, single registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sudi_store (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire sudi_pkg::idx_type wr_addr,
   input  wire sudi_pkg::elem_type wr_data,
   input  wire sudi_pkg::idx_type rd_addr,
   output sudi_pkg::elem_type     rd_data
);
   import sudi_pkg::*;

   elem_type store_mem [DEPTH];
   elem_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : sudi_store

`default_nettype wire

// ----- rtl/core/set_union_difference_intersection.sv -----
// ---------------------------------------------------------------------------
// set_union_difference_intersection
// collects two sets and emits their union, difference or intersection
// ---------------------------------------------------------------------------
// an append transaction leaves busy low
// a run fetches and latches each outer element, then compares it against the
// inner elements one per cycle until a hit (single equality comparator, one
// store read per cycle), and ends in a finish state that emits the last one
// results trail their decision by one element; the last one arrives as busy goes low
// reset clears counts, overflow flag and sequencer; stores are not cleared
// the receiver cannot stall: each result is a one-cycle strobe
`timescale 1ns / 1ps
`default_nettype none

module set_union_difference_intersection (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire sudi_pkg::code_type req_mode,
   input  wire sudi_pkg::elem_type req_element,
   input  wire sudi_pkg::code_type req_operation,
   output logic                    rsp_valid,
   output sudi_pkg::elem_type      rsp_result_element,
   output logic                    rsp_last,
   output logic                    rsp_empty_res,
   output logic                    rsp_overflow
);
   import sudi_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,   // read outer element
      S_LATCH,   // capture outer element, start inner read
      S_SCAN,    // compare one inner element per cycle
      S_FINISH   // emit the final transaction
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;        // 0: first set outer, 1: second set outer
   code_type  op_ff, op_in;
   cnt_type   cnt_a_ff, cnt_a_in;
   cnt_type   cnt_b_ff, cnt_b_in;
   logic      dropped_ff, dropped_in;
   cnt_type   i_ff, i_in;
   idx_type   k_ff, k_in;
   elem_type  outer_ff, outer_in;
   elem_type  pend_ff, pend_in;
   logic      pend_valid_ff, pend_valid_in;

   logic      rsp_valid_ff, rsp_valid_in;
   elem_type  rsp_elem_ff, rsp_elem_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_empty_ff, rsp_empty_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   // store ports
   logic      we_a, we_b;
   idx_type   addr_a, addr_b, fetch_addr, scan_addr;
   elem_type  rd_a, rd_b;

   // datapath helpers
   elem_type  outer_rd, inner_rd, dec_value;
   cnt_type   outer_cnt, inner_cnt, i_next, k_plus;
   logic      match, k_last, decide, found, emit;

   // ------------------------------------------------------------------
   // stores
   // ------------------------------------------------------------------
   assign we_a = (state_ff == S_IDLE) && start && (req_mode == MODE_FIRST)
                 && (cnt_a_ff < DEPTH_CNT);
   assign we_b = (state_ff == S_IDLE) && start && (req_mode == MODE_SECOND)
                 && (cnt_b_ff < DEPTH_CNT);

   // outer store reads element i while fetching, inner store walks k
   assign fetch_addr = (state_ff == S_FETCH) ? i_ff[IDX_W-1:0] : '0;
   assign scan_addr  = (state_ff == S_SCAN)  ? idx_type'(k_ff + 1'b1) : '0;
   assign addr_a     = phase_ff ? scan_addr  : fetch_addr;
   assign addr_b     = phase_ff ? fetch_addr : scan_addr;

   sudi_store u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (cnt_a_ff[IDX_W-1:0]),
      .wr_data (req_element),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   sudi_store u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (cnt_b_ff[IDX_W-1:0]),
      .wr_data (req_element),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   // ------------------------------------------------------------------
   // shared comparator and loop bounds
   // ------------------------------------------------------------------
   assign outer_rd  = phase_ff ? rd_b : rd_a;
   assign inner_rd  = phase_ff ? rd_a : rd_b;
   assign outer_cnt = phase_ff ? cnt_b_ff : cnt_a_ff;
   // first pass of a union emits everything, so nothing to search
   assign inner_cnt = ((op_ff == OP_UNION) && !phase_ff) ? '0
                    : (phase_ff ? cnt_a_ff : cnt_b_ff);
   assign i_next    = i_ff + cnt_type'(1);
   assign k_plus    = cnt_type'(k_ff) + cnt_type'(1);
   assign match     = (inner_rd == outer_ff);
   assign k_last    = (k_plus == inner_cnt);
   assign emit      = (op_ff == OP_INTERSECT) ? found : !found;

   // ------------------------------------------------------------------
   // sequencer next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      dropped_in    = dropped_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      outer_in      = outer_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      decide        = 1'b0;
      found         = 1'b0;
      dec_value     = outer_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_FIRST: begin
                     if (cnt_a_ff < DEPTH_CNT) begin
                        cnt_a_in = cnt_a_ff + cnt_type'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  MODE_SECOND: begin
                     if (cnt_b_ff < DEPTH_CNT) begin
                        cnt_b_in = cnt_b_ff + cnt_type'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  MODE_RUN: begin
                     op_in    = req_operation;
                     phase_in = 1'b0;
                     i_in     = '0;
                     if ((req_operation == OP_UNION) || (req_operation == OP_DIFF)
                         || (req_operation == OP_INTERSECT)) begin
                        if (cnt_a_ff != '0) begin
                           state_in = S_FETCH;
                        end else if ((req_operation == OP_UNION)
                                     && (cnt_b_ff != '0)) begin
                           phase_in = 1'b1;
                           state_in = S_FETCH;
                        end else begin
                           state_in = S_FINISH;
                        end
                     end else begin
                        // unknown operation: empty result
                        state_in = S_FINISH;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_FETCH: begin
            state_in = S_LATCH;
         end

         S_LATCH: begin
            outer_in = outer_rd;
            k_in     = '0;
            if (inner_cnt == '0) begin
               decide    = 1'b1;
               dec_value = outer_rd;
            end else begin
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // stop at the first hit: at most one emit per outer entry
            if (match || k_last) begin
               decide = 1'b1;
               found  = match;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_ovf_in    = dropped_ff;
            if (pend_valid_ff) begin
               rsp_elem_in  = pend_ff;
               rsp_empty_in = 1'b0;
            end else begin
               rsp_elem_in  = '0;
               rsp_empty_in = 1'b1;
            end
            pend_valid_in = 1'b0;
            cnt_a_in      = '0;
            cnt_b_in      = '0;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      if (decide) begin
         // hold the newest hit back so the final one can carry last
         if (emit) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = dropped_ff;
            end
            pend_in       = dec_value;
            pend_valid_in = 1'b1;
         end
         // advance the outer loop
         if (i_next < outer_cnt) begin
            i_in     = i_next;
            state_in = S_FETCH;
         end else if ((op_ff == OP_UNION) && !phase_ff && (cnt_b_ff != '0)) begin
            phase_in = 1'b1;
            i_in     = '0;
            state_in = S_FETCH;
         end else begin
            state_in = S_FINISH;
         end
      end
   end

   // ------------------------------------------------------------------
   // state and registered outputs
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= 1'b0;
         op_ff         <= OP_UNION;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         dropped_ff    <= 1'b0;
         i_ff          <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         op_ff         <= op_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         dropped_ff    <= dropped_in;
         i_ff          <= i_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      outer_ff     <= outer_in;
      pend_ff      <= pend_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_element = rsp_elem_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_empty_res      = rsp_empty_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_finish_gives_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (rsp_valid && rsp_last))
      else $error("finish cycle did not produce a last transaction");

   a_last_only_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> $past(state_ff == S_FINISH))
      else $error("last transaction outside finish");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> rsp_last)
      else $error("empty transaction without last");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= DEPTH_CNT) && (cnt_b_ff <= DEPTH_CNT))
      else $error("set count beyond store depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (k_plus <= inner_cnt))
      else $error("inner scan index past set count");

endmodule : set_union_difference_intersection

`default_nettype wire

// ----- tb/tb_set_union_difference_intersection.sv -----
// ---------------------------------------------------------------------------
// tb_set_union_difference_intersection
// self-checking bench for the set union / difference / intersection engine:
// loads both sets with appends, runs every operation, and compares each
// result transaction against a set-level prediction kept in a scoreboard
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_set_union_difference_intersection;
   import sudi_pkg::*;

   // codes the package does not name: an unused mode and an unused operation
   localparam code_type MODE_NONE = 2'd3;
   localparam code_type OP_NONE   = 2'd3;

   localparam elem_type ELEM_MIN = 32'sh8000_0000;
   localparam elem_type ELEM_MAX = 32'sh7fff_ffff;

   // quiet cycles allowed before the run is declared hung; it must outlast a
   // full union walk and the longest sender gap
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = DEPTH * (DEPTH + 4) + 50;
   localparam int MAX_GAP        = 40;
   localparam int MAX_REPORTS    = 100;

   // one expected result transaction
   typedef struct packed {
      elem_type value;
      logic     last;
      logic     empty;
      logic     ovf;
   } member_rec;

   // -------------------------------------------------------------------------
   // scoreboard: tracks both sets, predicts run output, checks results
   // -------------------------------------------------------------------------
   class set_op_checker;
      elem_type  first_set[$];
      elem_type  second_set[$];
      bit        dropped;
      member_rec pending_members[$];
      int        errors;
      int        runs;
      int        members_seen;
      int        drops;

      function bit holds(elem_type pool[$], elem_type v);
         foreach (pool[k])
            if (pool[k] == v)
               return 1'b1;
         return 1'b0;
      endfunction

      function member_rec make_row(elem_type v);
         member_rec row;
         row.value = v;
         row.last  = 1'b0;
         row.empty = 1'b0;
         row.ovf   = dropped;
         return row;
      endfunction

      // called once per accepted request transaction, in acceptance order
      function void note_request(code_type mode, elem_type elem, code_type op);
         member_rec out_rows[$];
         member_rec row;
         case (mode)
            MODE_FIRST: begin
               if (first_set.size() < DEPTH) begin
                  first_set.push_back(elem);
               end else begin
                  dropped = 1'b1;
                  drops++;
               end
            end
            MODE_SECOND: begin
               if (second_set.size() < DEPTH) begin
                  second_set.push_back(elem);
               end else begin
                  dropped = 1'b1;
                  drops++;
               end
            end
            MODE_RUN: begin
               runs++;
               if (op == OP_UNION) begin
                  foreach (first_set[i])
                     out_rows.push_back(make_row(first_set[i]));
                  foreach (second_set[i])
                     if (!holds(first_set, second_set[i]))
                        out_rows.push_back(make_row(second_set[i]));
               end else if (op == OP_DIFF) begin
                  foreach (first_set[i])
                     if (!holds(second_set, first_set[i]))
                        out_rows.push_back(make_row(first_set[i]));
               end else if (op == OP_INTERSECT) begin
                  // each first-set entry at most once, however often it
                  // appears in the second set
                  foreach (first_set[i])
                     if (holds(second_set, first_set[i]))
                        out_rows.push_back(make_row(first_set[i]));
               end
               if (out_rows.size() == 0) begin
                  row = make_row('0);
                  row.empty = 1'b1;
                  out_rows.push_back(row);
               end
               out_rows[out_rows.size() - 1].last = 1'b1;
               foreach (out_rows[i])
                  pending_members.push_back(out_rows[i]);
               first_set.delete();
               second_set.delete();
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch: %s", what);
      endtask

      task check_member(elem_type v, logic last, logic empty, logic ovf);
         member_rec want;
         if (pending_members.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", v));
            return;
         end
         want = pending_members.pop_front();
         members_seen++;
         if (v !== want.value)
            report($sformatf("result %0d: element %0d, expected %0d",
                             members_seen, v, want.value));
         if (last !== want.last)
            report($sformatf("result %0d: last %b, expected %b",
                             members_seen, last, want.last));
         if (empty !== want.empty)
            report($sformatf("result %0d: empty %b, expected %b",
                             members_seen, empty, want.empty));
         if (ovf !== want.ovf)
            report($sformatf("result %0d: overflow %b, expected %b",
                             members_seen, ovf, want.ovf));
      endtask

      task check_drained();
         if (pending_members.size() != 0)
            report($sformatf("%0d expected results never arrived",
                             pending_members.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     start         = 1'b0;
   code_type req_mode      = MODE_FIRST;
   elem_type req_element   = '0;
   code_type req_operation = OP_UNION;

   logic     busy;
   logic     rsp_valid;
   elem_type rsp_result_element;
   logic     rsp_last;
   logic     rsp_empty_res;
   logic     rsp_overflow;

   set_op_checker board;
   int            idle_pct;
   int            counted;
   elem_type      value_pool[4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   set_union_difference_intersection dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_element        (req_element),
      .req_operation      (req_operation),
      .rsp_valid          (rsp_valid),
      .rsp_result_element (rsp_result_element),
      .rsp_last           (rsp_last),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_overflow       (rsp_overflow)
   );

   // -------------------------------------------------------------------------
   // result monitor: the strobe cannot be held off, so every sampled strobe
   // is one result transaction; values are read before the edge updates them
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_member(rsp_result_element, rsp_last, rsp_empty_res,
                            rsp_overflow);
   end

   // -------------------------------------------------------------------------
   // watchdog: cycles in which neither side moves a transaction
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // request driver: optional random gap, then hold start until accepted;
   // start stays high across back-to-back transactions
   // -------------------------------------------------------------------------
   task automatic send_item(input code_type mode, input elem_type elem,
                            input code_type op);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         if (gap == 0)
            start <= 1'b0;
         @(posedge clock);
         gap++;
      end
      start         <= 1'b1;
      req_mode      <= mode;
      req_element   <= elem;
      req_operation <= op;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      board.note_request(mode, elem, op);
      if (mode != MODE_NONE)
         counted++;
   endtask

   // values drawn mostly from a small pool so membership tests hit often
   function automatic elem_type draw_value();
      if ($urandom_range(9) < 7)
         return value_pool[$urandom_range(3)];
      return elem_type'($urandom);
   endfunction

   function automatic int pick_size(input bit spill);
      if (spill)
         return ($urandom_range(2) == 0) ? int'($urandom_range(DEPTH + 2))
                                         : int'($urandom_range(DEPTH + 2, DEPTH - 1));
      if ($urandom_range(9) == 0)
         return ($urandom_range(1) == 0) ? DEPTH : DEPTH - 1;
      return $urandom_range(6);
   endfunction

   // one random batch: mostly a well-formed load of both sets followed by a
   // run; otherwise noise such as unknown modes, unknown ops, empty runs
   task automatic run_batch(input bit spill);
      int       n_first;
      int       n_second;
      int       n_noise;
      code_type op;
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(5))
            0:       value_pool[k] = ELEM_MIN;
            1:       value_pool[k] = ELEM_MAX;
            2:       value_pool[k] = elem_type'($urandom_range(3)) - 1;
            default: value_pool[k] = elem_type'($urandom);
         endcase
      end
      if ($urandom_range(99) < 80) begin
         n_first  = pick_size(spill);
         n_second = pick_size(spill);
         while (n_first + n_second > 0) begin
            // append op field is don't-care, so randomize it too
            if (n_second == 0 || (n_first > 0 && $urandom_range(1) == 1)) begin
               send_item(MODE_FIRST, draw_value(), code_type'($urandom_range(3)));
               n_first--;
            end else begin
               send_item(MODE_SECOND, draw_value(), code_type'($urandom_range(3)));
               n_second--;
            end
         end
         op = ($urandom_range(19) == 0) ? OP_NONE : code_type'($urandom_range(2));
         send_item(MODE_RUN, elem_type'($urandom), op);
      end else begin
         n_noise = $urandom_range(4);
         for (int k = 0; k < n_noise; k++)
            send_item(code_type'($urandom_range(3)), draw_value(),
                      code_type'($urandom_range(3)));
         send_item(MODE_RUN, elem_type'($urandom), code_type'($urandom_range(3)));
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      board    = new();
      idle_pct = 0;
      counted  = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // union of two empty sets gives the single empty transaction
      send_item(MODE_RUN, ELEM_MAX, OP_UNION);

      // union with field extremes; repeats in the second set are kept
      send_item(MODE_FIRST,  ELEM_MIN, OP_NONE);
      send_item(MODE_FIRST,  ELEM_MAX, OP_UNION);
      send_item(MODE_FIRST,  '0,       OP_DIFF);
      send_item(MODE_FIRST,  -1,       OP_INTERSECT);
      send_item(MODE_SECOND, -1,       OP_UNION);
      send_item(MODE_SECOND, 5,        OP_NONE);
      send_item(MODE_SECOND, 5,        OP_DIFF);
      send_item(MODE_SECOND, ELEM_MIN, OP_UNION);
      send_item(MODE_RUN,    ELEM_MIN, OP_UNION);

      // difference keeps only the first-set entry absent from the second
      send_item(MODE_FIRST,  7, OP_UNION);
      send_item(MODE_FIRST,  7, OP_UNION);
      send_item(MODE_FIRST,  3, OP_UNION);
      send_item(MODE_SECOND, 7, OP_UNION);
      send_item(MODE_SECOND, 9, OP_UNION);
      send_item(MODE_RUN,    -1, OP_DIFF);

      // intersection with a value repeated in the second set: emitted once
      send_item(MODE_FIRST,  4, OP_UNION);
      send_item(MODE_FIRST,  9, OP_UNION);
      send_item(MODE_SECOND, 4, OP_UNION);
      send_item(MODE_SECOND, 4, OP_UNION);
      send_item(MODE_SECOND, 9, OP_UNION);
      send_item(MODE_RUN,    0, OP_INTERSECT);

      // unknown operation: empty result, sets still cleared
      send_item(MODE_FIRST, 1, OP_UNION);
      send_item(MODE_RUN,   0, OP_NONE);

      // unknown mode is ignored, then a union proves the sets were cleared
      send_item(MODE_NONE, 12345, OP_UNION);
      send_item(MODE_RUN,  0,     OP_UNION);

      // random traffic: sender idles now and then, then most of the time,
      // then never
      idle_pct = 26;
      while (counted < 80)
         run_batch(1'b0);
      idle_pct = 87;
      while (counted < 145)
         run_batch(1'b0);
      idle_pct = 0;
      while (counted < 205)
         run_batch(1'b0);

      // full and overflowing sets last, since the overflow flag is sticky
      for (int k = 0; k < 4; k++)
         run_batch(1'b1);
      // make sure at least one append is dropped
      for (int k = 0; k <= DEPTH; k++)
         send_item(MODE_SECOND, elem_type'($urandom), OP_UNION);
      send_item(MODE_RUN, 0, OP_DIFF);
      start <= 1'b0;

      // drain, then allow for stray results
      while (board.pending_members.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      board.check_drained();

      $display("run covered %0d request transactions, %0d set operations",
               counted, board.runs);
      $display("checked %0d result transactions, %0d appends dropped, %0d mismatches",
               board.members_seen, board.drops, board.errors);
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
